FILE: src/ffba_pkg.sv
// Shared types, codes and the lowest-free-bit search for the block bitmap allocator.
package ffba_pkg;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_MARK  = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNMOUNTED = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [10:0] map_entries;
		logic [9:0]  inode_block_count;
		logic        map_mounted;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} mem_ctl_t;

	typedef struct packed {
		logic       found;
		logic [4:0] idx;
	} lz_t;

	// Lowest clear bit of a map word
	function automatic lz_t low_zero(input logic [31:0] word);
		lz_t r;
		r.found = 1'b0;
		r.idx   = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (!word[i]) begin
				r.found = 1'b1;
				r.idx   = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: src/first_fit_block_bitmap_allocator.sv
// Top level: request sequencer over the word-wide block map memory.
//
//  channel   direction  handshake              payload
//  request   in         req_valid/req_ready    action, disk_block
//  response  out        rsp_valid/rsp_ready    granted_block, status
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
// Allocate scans the 32-bit map words until a free bit turns up, at most ceil(entries/32);
// free and mark rewrite one word in S_RMW; clear and refused requests skip both.
// The single read port of the map memory sets the scan at one word per cycle.
// Reset clears the registers and the word valid bits at once; no clearing pass follows.
// A held response stalls the sequencer in its final state; a new request is taken as soon
// as the sequencer is back to idle, while the previous response may still be waiting.
module first_fit_block_bitmap_allocator #(
	parameter int MAP_BITS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [15:0] disk_block,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] granted_block,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffba_pkg::*;

	// The map size register is 11 bits, so bits at or above 2047 are never reached
	localparam int EFF_BITS = (MAP_BITS < 2047) ? MAP_BITS : 2047;
	localparam int DEPTH    = (EFF_BITS + 31) / 32;
	localparam int WA       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RMW,
		S_DONE
	} state_t;

	state_t        state_q;
	cfg_t          cfg;
	mem_ctl_t      mem_ctl;
	logic [WA-1:0] rd_addr;
	logic [WA-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [31:0]   rd_data;

	logic          req_accept;
	act_t          act;
	logic [10:0]   n_live;
	logic [10:0]   n_m1;
	logic [10:0]   first;
	logic [15:0]   blk_off;
	logic          blk_bad;
	logic [WA-1:0] last_w;
	logic [31:0]   tail_mask;
	lz_t           lz;
	logic [31:0]   bit_oh;
	logic [15:0]   grant_calc;

	logic [WA-1:0] cur_w_s1;
	logic [4:0]    bit_q;
	logic          mark_q;
	logic [15:0]   res_grant_q;
	status_t       res_status_q;
	logic          rsp_vld_q;
	logic [15:0]   rsp_grant_q;
	status_t       rsp_status_q;

	ffba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffba_mem #(
		.DEPTH (DEPTH),
		.AW    (WA)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign req_ready  = (state_q == S_IDLE);
	assign req_accept = req_valid && req_ready;
	assign act        = act_t'(action);

	assign n_live  = ({21'd0, cfg.map_entries} > 32'(MAP_BITS)) ? 11'(MAP_BITS)
	                                                            : cfg.map_entries;
	assign n_m1    = n_live - 11'd1;
	assign last_w  = n_m1[5 +: WA];
	assign first   = {1'b0, cfg.inode_block_count} + 11'd1;
	assign blk_off = disk_block - {5'd0, first};
	assign blk_bad = (disk_block < {5'd0, first}) || (blk_off >= {5'd0, n_live});

	// Treat bits past the last tracked entry as taken
	assign tail_mask = ((cur_w_s1 == last_w) && (n_live[4:0] != 5'd0))
	                   ? ~((32'd1 << n_live[4:0]) - 32'd1) : 32'd0;
	assign lz         = low_zero(rd_data | tail_mask);
	assign bit_oh     = (state_q == S_SCAN) ? (32'd1 << lz.idx) : (32'd1 << bit_q);
	assign grant_calc = {5'd0, first} + 16'({cur_w_s1, lz.idx});

	always_comb begin
		mem_ctl = '0;
		rd_addr = '0;
		wr_addr = cur_w_s1;
		wr_data = rd_data | bit_oh;
		unique case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					if (act == ACT_CLEAR) begin
						mem_ctl.clr = 1'b1;
					end else if (cfg.map_mounted) begin
						if (act == ACT_ALLOC) begin
							mem_ctl.rd_en = (n_live != 11'd0);
						end else begin
							mem_ctl.rd_en = !blk_bad;
							rd_addr       = blk_off[5 +: WA];
						end
					end
				end
			end
			S_SCAN: begin
				if (lz.found) begin
					mem_ctl.wr_en = 1'b1;
				end else if (cur_w_s1 != last_w) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = cur_w_s1 + WA'(1);
				end
			end
			S_RMW: begin
				mem_ctl.wr_en = 1'b1;
				wr_data       = mark_q ? (rd_data | bit_oh) : (rd_data & ~bit_oh);
			end
			S_DONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_w_s1     <= '0;
			bit_q        <= '0;
			mark_q       <= 1'b0;
			res_grant_q  <= '0;
			res_status_q <= ST_OK;
			rsp_vld_q    <= 1'b0;
			rsp_grant_q  <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			if (rsp_vld_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						res_grant_q <= '0;
						state_q     <= S_DONE;
						if (act == ACT_CLEAR) begin
							res_status_q <= ST_OK;
						end else if (!cfg.map_mounted) begin
							res_status_q <= ST_UNMOUNTED;
						end else if (act == ACT_ALLOC) begin
							res_status_q <= ST_FULL;
							cur_w_s1     <= '0;
							if (n_live != 11'd0) begin
								state_q <= S_SCAN;
							end
						end else if (blk_bad) begin
							res_status_q <= ST_RANGE;
						end else begin
							res_status_q <= ST_OK;
							cur_w_s1     <= blk_off[5 +: WA];
							bit_q        <= blk_off[4:0];
							mark_q       <= (act == ACT_MARK);
							state_q      <= S_RMW;
						end
					end
				end
				S_SCAN: begin
					if (lz.found) begin
						res_grant_q  <= grant_calc;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end else if (cur_w_s1 == last_w) begin
						state_q <= S_DONE;
					end else begin
						cur_w_s1 <= cur_w_s1 + WA'(1);
					end
				end
				S_RMW: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the response register is free
					if (!rsp_vld_q || rsp_ready) begin
						rsp_vld_q    <= 1'b1;
						rsp_grant_q  <= res_grant_q;
						rsp_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_vld_q;
	assign granted_block = rsp_grant_q;
	assign status        = rsp_status_q;

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> granted_block == 16'd0)
		else $error("block granted with a failing status");

	a_grant_in_data_area: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (granted_block != 16'd0) |->
			granted_block > {6'd0, cfg.inode_block_count})
		else $error("granted block lies below the data area");

	a_no_clear_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.clr |-> !mem_ctl.wr_en && !mem_ctl.rd_en)
		else $error("map clear overlaps a map access");

	a_scan_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && mem_ctl.wr_en |=> state_q == S_DONE)
		else $error("scan carried on after marking a block");

endmodule

FILE: src/ffba_cfg.sv
// APB register file holding the map size, the inode block count and the mount flag.
module ffba_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ffba_pkg::cfg_t    cfg
);
	import ffba_pkg::*;

	typedef enum logic [1:0] {
		REG_ENTRIES = 2'd0,
		REG_INODES  = 2'd1,
		REG_MOUNT   = 2'd2
	} reg_idx_t;

	cfg_t cfg_q;
	logic wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_hit) begin
			unique case (paddr[3:2])
				REG_ENTRIES: cfg_q.map_entries       <= pwdata[10:0];
				REG_INODES:  cfg_q.inode_block_count <= pwdata[9:0];
				REG_MOUNT:   cfg_q.map_mounted       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ENTRIES: prdata = {21'd0, cfg_q.map_entries};
			REG_INODES:  prdata = {22'd0, cfg_q.inode_block_count};
			REG_MOUNT:   prdata = {31'd0, cfg_q.map_mounted};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

FILE: src/ffba_mem.sv
// Word-wide map memory with one read and one write port and per-word valid bits.
module ffba_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffba_pkg::mem_ctl_t   ctl,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  logic [31:0]          wr_data,
	output logic [31:0]          rd_data
);
	import ffba_pkg::*;

	logic [31:0]      mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      rdata_s1;
	logic             rvld_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// A word never written since the last clear reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_s1 ? rdata_s1 : 32'd0;

endmodule
